// ----- src/bsg_pkg.sv -----
package bsg_pkg;

    localparam int CW   = 32;
    localparam int SUMW = CW + 2;
    localparam int PW   = 2 * CW + 2;
    localparam int DW   = CW + 1;
    localparam int RW   = DW + 2;
    localparam int CNTW = 6;

    localparam logic [CNTW-1:0] MUL_LAST  = CNTW'(CW - 1);
    localparam logic [CNTW-1:0] ROOT_LAST = CNTW'(DW - 1);
    localparam logic [CNTW-1:0] DIV_LAST  = CNTW'(CW - 1);

    typedef struct packed {
        logic load;
        logic step;
    } t_eng_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQUARE,
        ST_SUM,
        ST_CMP,
        ST_ROOT,
        ST_SETUP,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_WB
    } t_state;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_KEEP,
        MODE_GROW
    } t_mode;

endpackage

// ----- src/bsg_smul.sv -----
module bsg_smul
    import bsg_pkg::*;
(
    input  logic            i_clk,
    input  t_eng_ctl        i_ctl,
    input  logic [SUMW-1:0] i_mcand,
    input  logic [CW-1:0]   i_mplier,
    output logic [PW-1:0]   o_prod
);

    logic [SUMW-1:0] r_hi;
    logic [CW-1:0]   r_lo;
    logic [SUMW:0]   hi_sum;

    // shift-add, one multiplier bit per cycle while step is set
    assign hi_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, i_mcand} : '0);
    assign o_prod = {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hi <= '0;
            r_lo <= i_mplier;
        end else if (i_ctl.step) begin
            r_hi <= hi_sum[SUMW:1];
            r_lo <= {hi_sum[0], r_lo[CW-1:1]};
        end
    end

endmodule

// ----- src/bsg_sdiv.sv -----
module bsg_sdiv
    import bsg_pkg::*;
(
    input  logic            i_clk,
    input  t_eng_ctl        i_ctl,
    input  logic [PW-1:0]   i_num,
    input  logic [SUMW-1:0] i_den,
    output logic [CW-1:0]   o_quot
);

    logic [SUMW-1:0] r_rem;
    logic [CW-1:0]   r_n;
    logic [SUMW:0]   t;
    logic [SUMW:0]   diff;
    logic            ge;

    // restoring division, one quotient bit per cycle while step is set
    assign t      = {r_rem, r_n[CW-1]};
    assign ge     = t >= {1'b0, i_den};
    assign diff   = t - {1'b0, i_den};
    assign o_quot = r_n;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_num[PW-1:CW];
            r_n   <= i_num[CW-1:0];
        end else if (i_ctl.step) begin
            r_rem <= ge ? diff[SUMW-1:0] : t[SUMW-1:0];
            r_n   <= {r_n[CW-2:0], ge};
        end
    end

endmodule

// ----- src/bsg_sqrt.sv -----
module bsg_sqrt
    import bsg_pkg::*;
(
    input  logic          i_clk,
    input  t_eng_ctl      i_ctl,
    input  logic [PW-1:0] i_rad,
    output logic [DW-1:0] o_root
);

    logic [PW-1:0] r_s;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_root;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;

    // restoring square root, two radicand bits per cycle while step is set
    assign t      = {r_rem, r_s[PW-1:PW-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = t >= trial;
    assign diff   = t - trial;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            r_s    <= {r_s[PW-3:0], 2'b00};
            r_rem  <= ge ? diff[RW-1:0] : t[RW-1:0];
            r_root <= {r_root[DW-2:0], ge};
        end
    end

endmodule

// ----- src/bounding_sphere_grow.sv -----
// running bounding sphere over a stream of 3d points, signed q16.16
// s_axis: one point per transaction, tdata = {z, y, x} (x lowest),
//   tuser[0] = start of a new point set
// m_axis: one sphere per point, tdata = {radius, cz, cy, cx} (cx lowest),
//   tuser[0] = grew, tuser[1] = saturated
// a point is taken only when the block is idle; a point that starts a set
// goes from acceptance through the prep state straight to write-back, a
// point inside the sphere through prep, serial squaring, sum and compare
// states, and a point outside the sphere through a serial squaring of the
// offsets, a square root, a serial multiply and a serial divide, each one
// bit or digit per cycle; the next point is taken in the cycle after the
// result is written, so a new point is taken only once the last is through
// the three axes run in parallel lanes
// reset clears the held sphere and marks no set as started; the next
// point then starts a set
// when the receiver stalls the result stays on m_axis and the block
// holds its finished sphere until that transaction completes
module bounding_sphere_grow
    import bsg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [3*CW-1:0]     s_axis_tdata,   // point_x, point_y, point_z
    input  logic                s_axis_tuser,   // start_set
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [4*CW-1:0]     m_axis_tdata,   // center_x, center_y, center_z, sphere_radius
    output logic [1:0]          m_axis_tuser    // grew, saturated
);

    t_state r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    t_mode  r_mode;
    logic   r_active;
    logic   r_start;

    logic signed [CW-1:0] r_p [3];
    logic signed [CW-1:0] r_c [3];
    logic        [CW-1:0] r_ad [3];
    logic                 r_neg [3];
    logic        [CW-1:0] r_rad;
    logic        [PW-1:0] r_s;
    logic      [SUMW-1:0] r_sum;

    logic [CW-1:0]   ad_c [3];
    logic            neg_c [3];
    logic [PW-1:0]   prod [3];
    logic [CW-1:0]   quot [3];
    logic [PW-1:0]   rsq;
    logic [DW-1:0]   root;
    logic [CW-1:0]   mplier [3];
    logic signed [CW-1:0] nc [3];
    logic            csat [3];
    logic [CW-1:0]   nr;
    logic            rsat;

    t_eng_ctl ctl_mul, ctl_rsq, ctl_root, ctl_div;
    logic     wb_fire;
    logic     out_free;

    logic r_ovalid;
    logic [4*CW-1:0] r_odata;
    logic [1:0] r_ouser;

    assign out_free = !r_ovalid || m_axis_tready;
    assign wb_fire  = (r_state == ST_WB) && out_free;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [CW:0]     dx;
        logic signed [CW+1:0]   pe;
        logic signed [CW+1:0]   sum_c;
        logic        [CW-1:0]   qc;
        logic        [SUMW-1:0] lane_mcand;

        assign dx       = {r_c[g][CW-1], r_c[g]} - {r_p[g][CW-1], r_p[g]};
        assign neg_c[g] = dx[CW];
        assign ad_c[g]  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        assign mplier[g] = (r_state == ST_PREP) ? ad_c[g] : r_ad[g];
        assign lane_mcand = (r_state == ST_MUL) ? r_sum : {2'b00, r_ad[g]};

        bsg_smul u_mul (
            .i_clk    (i_clk),
            .i_ctl    (ctl_mul),
            .i_mcand  ((r_state == ST_SQUARE) ? {2'b00, r_ad[g]} : lane_mcand),
            .i_mplier (mplier[g]),
            .o_prod   (prod[g])
        );

        bsg_sdiv u_div (
            .i_clk  (i_clk),
            .i_ctl  (ctl_div),
            .i_num  (prod[g]),
            .i_den  ({root, 1'b0}),
            .o_quot (quot[g])
        );

        assign qc    = (quot[g] > r_ad[g]) ? r_ad[g] : quot[g];
        assign pe    = {{2{r_p[g][CW-1]}}, r_p[g]};
        assign sum_c = r_neg[g] ? pe - $signed({2'b00, qc}) : pe + $signed({2'b00, qc});

        always_comb begin
            csat[g] = 1'b0;
            nc[g]   = sum_c[CW-1:0];
            if (sum_c > $signed({{2{1'b0}}, 1'b0, {(CW-1){1'b1}}})) begin
                nc[g]   = {1'b0, {(CW-1){1'b1}}};
                csat[g] = 1'b1;
            end else if (sum_c < $signed({{2{1'b1}}, 1'b1, {(CW-1){1'b0}}})) begin
                nc[g]   = {1'b1, {(CW-1){1'b0}}};
                csat[g] = 1'b1;
            end
        end
    end

    bsg_smul u_rsq (
        .i_clk    (i_clk),
        .i_ctl    (ctl_rsq),
        .i_mcand  ({2'b00, r_rad}),
        .i_mplier (r_rad),
        .o_prod   (rsq)
    );

    bsg_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_ctl  (ctl_root),
        .i_rad  (r_s),
        .o_root (root)
    );

    assign rsat = r_sum[SUMW-1];
    assign nr   = rsat ? '1 : r_sum[CW:1];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_PREP;
            ST_PREP:   n_state = (r_start || !r_active) ? ST_WB : ST_SQUARE;
            ST_SQUARE: if (r_cnt == MUL_LAST) n_state = ST_SUM;
            ST_SUM:    n_state = ST_CMP;
            ST_CMP:    n_state = (r_s > rsq) ? ST_ROOT : ST_WB;
            ST_ROOT:   if (r_cnt == ROOT_LAST) n_state = ST_SETUP;
            ST_SETUP:  n_state = ST_MUL;
            ST_MUL:    if (r_cnt == MUL_LAST) n_state = ST_DLOAD;
            ST_DLOAD:  n_state = ST_DIV;
            ST_DIV:    if (r_cnt == DIV_LAST) n_state = ST_WB;
            ST_WB:     if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        ctl_mul  = '0;
        ctl_rsq  = '0;
        ctl_root = '0;
        ctl_div  = '0;
        n_cnt    = '0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_PREP: begin
                ctl_mul.load = 1'b1;
                ctl_rsq.load = 1'b1;
            end
            ST_SQUARE: begin
                ctl_mul.step = 1'b1;
                ctl_rsq.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            ST_CMP: ctl_root.load = 1'b1;
            ST_ROOT: begin
                ctl_root.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            ST_SETUP: ctl_mul.load = 1'b1;
            ST_MUL: begin
                ctl_mul.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            ST_DLOAD: ctl_div.load = 1'b1;
            ST_DIV: begin
                ctl_div.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_rad    <= '0;
            for (int i = 0; i < 3; i++) r_c[i] <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (wb_fire) begin
                r_ovalid <= 1'b1;
                case (r_mode)
                    MODE_START: begin
                        r_active <= 1'b1;
                        r_rad    <= '0;
                        for (int i = 0; i < 3; i++) r_c[i] <= r_p[i];
                    end
                    MODE_GROW: begin
                        r_rad <= nr;
                        for (int i = 0; i < 3; i++) r_c[i] <= nc[i];
                    end
                    default: ;
                endcase
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_start <= s_axis_tuser;
            for (int i = 0; i < 3; i++) r_p[i] <= s_axis_tdata[i*CW +: CW];
        end
        if (r_state == ST_PREP) begin
            r_mode <= (r_start || !r_active) ? MODE_START : MODE_KEEP;
            for (int i = 0; i < 3; i++) begin
                r_ad[i]  <= ad_c[i];
                r_neg[i] <= neg_c[i];
            end
        end
        if (r_state == ST_SUM) begin
            r_s <= prod[0] + prod[1] + prod[2];
        end
        if (r_state == ST_CMP && r_s > rsq) begin
            r_mode <= MODE_GROW;
        end
        if (r_state == ST_SETUP) begin
            r_sum <= {1'b0, root} + {2'b00, r_rad};
        end
        if (wb_fire) begin
            case (r_mode)
                MODE_START: begin
                    r_odata <= {{CW{1'b0}}, r_p[2], r_p[1], r_p[0]};
                    r_ouser <= 2'b00;
                end
                MODE_GROW: begin
                    r_odata <= {nr, nc[2], nc[1], nc[0]};
                    r_ouser <= {rsat || csat[0] || csat[1] || csat[2], 1'b1};
                end
                default: begin
                    r_odata <= {r_rad, r_c[2], r_c[1], r_c[0]};
                    r_ouser <= 2'b00;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

// ----- src/bsg_checker.sv -----
module bsg_checker
    import bsg_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            s_axis_tvalid,
    input logic            s_axis_tready,
    input logic [3*CW-1:0] s_axis_tdata,
    input logic            s_axis_tuser,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [4*CW-1:0] m_axis_tdata,
    input logic [1:0]      m_axis_tuser
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("m_axis result changed under stall");

    // one point in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("s_axis ready right after a transaction");

    // saturation only on a growing step
    a_sat_grew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
        else $error("saturated without growth");

    // a new set starts with zero radius when the output is free
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |=> ##2
        (m_axis_tvalid && m_axis_tdata[4*CW-1:3*CW] == '0))
        else $error("start of set did not give zero radius");

endmodule

bind bounding_sphere_grow bsg_checker u_bsg_checker (.*);

// ----- tb/tb_checker.sv -----
module tb_checker
    import bsg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [3*CW-1:0]     s_axis_tdata,   // point_x, point_y, point_z
    input  logic                s_axis_tuser,   // start_set
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [4*CW-1:0]     m_axis_tdata,   // center_x, center_y, center_z, sphere_radius
    input  logic [1:0]          m_axis_tuser,   // grew, saturated
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [CW-1:0] cz;
        logic [CW-1:0] rad;
        logic          grew;
        logic          sat;
    } t_sphere;

    t_sphere sphere_q[$];
    logic signed [CW-1:0] ctr [3];
    logic [CW-1:0] rad;
    logic active;

    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (128'(t) * 128'(t) <= s) r = t;
        end
        return r;
    endfunction

    task automatic grow_sphere(input logic [3*CW-1:0] pt, input logic start);
        logic signed [63:0] p [3];
        logic signed [63:0] dx [3];
        logic [63:0] ad [3];
        logic [127:0] s;
        logic [63:0] d;
        logic [63:0] sum;
        logic [63:0] nr;
        logic [127:0] q;
        logic signed [63:0] nc;
        t_sphere e;
        e = '0;
        for (int i = 0; i < 3; i++) p[i] = 64'(signed'(pt[i*CW +: CW]));
        if (start || !active) begin
            for (int i = 0; i < 3; i++) ctr[i] = p[i][CW-1:0];
            rad = '0;
            active = 1'b1;
        end else begin
            s = '0;
            for (int i = 0; i < 3; i++) begin
                dx[i] = 64'(ctr[i]) - p[i];
                ad[i] = dx[i] < 0 ? -dx[i] : dx[i];
                s += 128'(ad[i]) * 128'(ad[i]);
            end
            if (s > 128'(rad) * 128'(rad)) begin
                d = isqrt(s);
                sum = d + 64'(rad);
                nr = sum >> 1;
                e.grew = 1'b1;
                if (nr > 64'hFFFF_FFFF) begin
                    nr = 64'hFFFF_FFFF;
                    e.sat = 1'b1;
                end
                for (int i = 0; i < 3; i++) begin
                    q = (128'(ad[i]) * 128'(sum)) / 128'(d << 1);
                    if (q > 128'(ad[i])) q = 128'(ad[i]);
                    nc = dx[i] < 0 ? p[i] - 64'(q) : p[i] + 64'(q);
                    if (nc > 64'sd2147483647) begin
                        nc = 64'sd2147483647;
                        e.sat = 1'b1;
                    end
                    if (nc < -64'sd2147483648) begin
                        nc = -64'sd2147483648;
                        e.sat = 1'b1;
                    end
                    ctr[i] = nc[CW-1:0];
                end
                rad = nr[CW-1:0];
            end
        end
        e.cx = ctr[0];
        e.cy = ctr[1];
        e.cz = ctr[2];
        e.rad = rad;
        sphere_q.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [CW-1:0] exp_v,
                               input logic [CW-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        active = 1'b0;
        rad = '0;
        for (int i = 0; i < 3; i++) ctr[i] = '0;
    end

    assign o_pending = sphere_q.size();

    always @(posedge i_clk) begin
        t_sphere e;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) grow_sphere(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                if (sphere_q.size() == 0) begin
                    $error("sphere transaction with no expectation");
                    o_fail_count++;
                end else begin
                    e = sphere_q.pop_front();
                    check_field("center_x", e.cx, m_axis_tdata[0 +: CW]);
                    check_field("center_y", e.cy, m_axis_tdata[CW +: CW]);
                    check_field("center_z", e.cz, m_axis_tdata[2*CW +: CW]);
                    check_field("sphere_radius", e.rad, m_axis_tdata[3*CW +: CW]);
                    check_field("grew", CW'(e.grew), CW'(m_axis_tuser[0]));
                    check_field("saturated", CW'(e.sat), CW'(m_axis_tuser[1]));
                end
            end
        end
    end
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bsg_pkg::*;

    localparam int N_RANDOM = 1500;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [3*CW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [4*CW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    int fail_count;
    int pending;
    int cycles = 0;
    bit hold_off = 1'b0;

    always #5 i_clk = ~i_clk;

    bounding_sphere_grow u_top (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    tb_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return CW'(signed'($urandom_range(0, 4000)) - 2000);
            3: return CW'(signed'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z, input logic start);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        s_axis_tuser <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern
    initial begin
        int mode;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 200)) begin
                @(posedge i_clk);
                if (hold_off) m_axis_tready <= 1'b0;
                else if (mode == 0) m_axis_tready <= 1'b1;
                else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
                else if (mode == 2) m_axis_tready <= ($urandom_range(0, 3) == 0);
                else m_axis_tready <= ~m_axis_tready;
            end
        end
    end

    initial begin
        logic [CW-1:0] bx, by, bz;
        int burst;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // no set started yet: acts as a start
        send_point(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0003_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0002_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0003_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b1);
        send_point(32'h0, 32'h0, 32'h1, 1'b0);
        send_point(32'h0, 32'h1, 32'h0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 1'b0);
        // receiver holds off while points keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_point(32'h0, 32'h0, 32'h0, 1'b1);
                send_point(32'h0, 32'h0, 32'h0, 1'b0);
                send_point(32'h0010_0000, 32'h0, 32'h0, 1'b0);
                send_point(32'h0, 32'h0020_0000, 32'h0, 1'b0);
            end
        join
        // sender waits for the block to drain
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        bx = '0;
        by = '0;
        bz = '0;
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    bx = rand_coord(); by = rand_coord(); bz = rand_coord();
                    send_point(bx, by, bz, 1'($urandom_range(0, 1)));
                end else if ($urandom_range(0, 15) == 0) begin
                    bx = rand_coord(); by = rand_coord(); bz = rand_coord();
                    send_point(bx, by, bz, 1'b1);
                end else begin
                    send_point(bx + CW'(signed'($urandom_range(0, 64)) - 32),
                               by + CW'(signed'($urandom_range(0, 64)) - 32),
                               bz + CW'(signed'($urandom_range(0, 64)) - 32), 1'b0);
                end
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60));
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
src/bsg_pkg.sv
src/bsg_smul.sv
src/bsg_sdiv.sv
src/bsg_sqrt.sv
src/bounding_sphere_grow.sv
src/bsg_checker.sv
tb/tb_checker.sv
tb/tb_top.sv
